### hdl/fp8rp_pkg.sv
// ----------------------------------------------------------------------------
// fp8rp_pkg
// shared types and constants of the fp8 e4m3 round and pack unit
// ----------------------------------------------------------------------------
package fp8rp_pkg;

  // payload widths
  localparam int unsigned ExpWidth    = 8;
  localparam int unsigned SigWidth    = 7;
  localparam int unsigned PackedWidth = 8;

  // apb map: register i at byte address 4*i
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam logic REG_IDX_MODE     = 1'b0;
  localparam logic REG_IDX_TININESS = 1'b1;

  // largest biased exponent that can still hold a finite result
  localparam logic signed [ExpWidth-1:0] EXP_MAX_FINITE = 8'sd13;
  // exponents below this flush the whole significand into the sticky bit
  localparam logic signed [ExpWidth-1:0] EXP_FULL_SHIFT = -8'sd7;
  localparam logic signed [ExpWidth-1:0] EXP_TINY_LIMIT = -8'sd1;

  localparam logic [2:0] INC_HALF = 3'h4;
  localparam logic [2:0] INC_FULL = 3'h7;
  localparam logic [2:0] RBITS_TIE = 3'h4;

  localparam logic [6:0] ENC_INF     = 7'h78;
  localparam logic [6:0] ENC_MAX_FIN = 7'h77;

  typedef enum logic [2:0] {
    RM_NEAR_EVEN   = 3'd0,
    RM_TO_ZERO     = 3'd1,
    RM_DOWN        = 3'd2,
    RM_UP          = 3'd3,
    RM_NEAR_MAXMAG = 3'd4,
    RM_ODD         = 3'd5
  } rnd_mode_e;

endpackage

### hdl/fp8rp_req_if.sv
// ----------------------------------------------------------------------------
// fp8rp_req_if
// request channel: sign, biased exponent and significand to be rounded
// ----------------------------------------------------------------------------
interface fp8rp_req_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      sign_in;
  logic signed [fp8rp_pkg::ExpWidth-1:0]     exponent_in;
  logic        [fp8rp_pkg::SigWidth-1:0]     significand_in;

  modport source (output valid, sign_in, exponent_in, significand_in, input ready);
  modport sink   (input valid, sign_in, exponent_in, significand_in, output ready);
endinterface

### hdl/fp8rp_res_if.sv
// ----------------------------------------------------------------------------
// fp8rp_res_if
// result channel: packed fp8 value and its exception flags
// ----------------------------------------------------------------------------
interface fp8rp_res_if;
  logic                                  valid;
  logic                                  ready;
  logic [fp8rp_pkg::PackedWidth-1:0]     packed_result;
  logic                                  inexact_flag;
  logic                                  underflow_flag;
  logic                                  overflow_flag;

  modport source (output valid, packed_result, inexact_flag, underflow_flag,
                  overflow_flag, input ready);
  modport sink   (input valid, packed_result, inexact_flag, underflow_flag,
                  overflow_flag, output ready);
endinterface

### hdl/fp8_round_and_pack_unit.sv
// ----------------------------------------------------------------------------
// fp8_round_and_pack_unit
// rounds sign, exponent and guarded significand to fp8 e4m3 and packs it
// ----------------------------------------------------------------------------
// A request is taken into an input register, rounded by one short
// combinational pass and written into the result register, which presents it
// on res_o. One request can be accepted every cycle while the result side
// is not stalled: the input register loads whenever it is empty or the
// result register moves on, and req_i.ready goes low only when both hold a
// request and res_o.ready is low. The rounding mode and tininess mode are
// written through the apb port (mode at 0x0, tininess at 0x4) and must only
// change while the unit is empty. Every result carries its own inexact,
// underflow and overflow flags; accumulating them is up to the user.
module fp8_round_and_pack_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  fp8rp_req_if.sink                            req_i,
  fp8rp_res_if.source                          res_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fp8rp_pkg::AddrWidth-1:0]      paddr,
  input  logic [fp8rp_pkg::DataWidth-1:0]      pwdata,
  output logic [fp8rp_pkg::DataWidth-1:0]      prdata,
  output logic                                 pready
);

  // configuration registers
  fp8rp_pkg::rnd_mode_e mode_q;
  logic                 tbr_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // only bit 2 of the address selects a register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fp8rp_pkg::RM_NEAR_EVEN;
      tbr_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fp8rp_pkg::REG_IDX_MODE:     mode_q <= fp8rp_pkg::rnd_mode_e'(pwdata[2:0]);
        fp8rp_pkg::REG_IDX_TININESS: tbr_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fp8rp_pkg::REG_IDX_MODE:     prdata = {29'b0, mode_q};
      fp8rp_pkg::REG_IDX_TININESS: prdata = {31'b0, tbr_q};
      default:                     prdata = '0;
    endcase
  end

  // pipeline control: the input stage also loads whenever it is empty
  logic s1_v_q, s2_v_q;
  logic s2_en, s1_en;

  assign s2_en       = ~s2_v_q | res_o.ready;
  assign s1_en       = ~s1_v_q | s2_en;
  assign req_i.ready = s1_en;

  // input register
  logic                                  s1_sign_q;
  logic signed [fp8rp_pkg::ExpWidth-1:0] s1_exp_q;
  logic [fp8rp_pkg::SigWidth-1:0]        s1_sig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && req_i.valid) begin
      s1_sign_q <= req_i.sign_in;
      s1_exp_q  <= req_i.exponent_in;
      s1_sig_q  <= req_i.significand_in;
    end
  end

  // rounding increment added below the kept bits
  logic [2:0] inc;
  always_comb begin
    unique case (mode_q)
      fp8rp_pkg::RM_NEAR_EVEN,
      fp8rp_pkg::RM_NEAR_MAXMAG: inc = fp8rp_pkg::INC_HALF;
      fp8rp_pkg::RM_DOWN:        inc = s1_sign_q ? fp8rp_pkg::INC_FULL : 3'h0;
      fp8rp_pkg::RM_UP:          inc = s1_sign_q ? 3'h0 : fp8rp_pkg::INC_FULL;
      default:                   inc = 3'h0;  // toward zero, odd, unused codes
    endcase
  end

  logic        exp_neg;
  logic        full_shift;
  logic [2:0]  shamt;
  logic [13:0] shifted;
  logic [6:0]  sig_tiny;
  logic [6:0]  sig_eff;
  logic [3:0]  exp_eff;
  logic [7:0]  sum_orig;
  logic [7:0]  sum_eff;
  logic        tiny;
  logic        ovf;
  logic [2:0]  rbits;
  logic        rnd_any;
  logic [4:0]  rsig;
  logic [3:0]  exp_pack;
  logic [8:0]  packed_sum;
  logic [7:0]  packed_d;
  logic        inexact_d, underflow_d;

  always_comb begin
    exp_neg    = s1_exp_q[fp8rp_pkg::ExpWidth-1];
    full_shift = s1_exp_q < fp8rp_pkg::EXP_FULL_SHIFT;
    shamt      = 3'(-s1_exp_q);
    sum_orig   = {1'b0, s1_sig_q} + {5'b0, inc};

    // sticky right shift for tiny values
    shifted  = {s1_sig_q, 7'b0} >> shamt;
    sig_tiny = full_shift ? {6'b0, |s1_sig_q}
                          : (shifted[13:7] | {6'b0, |shifted[6:0]});
    sig_eff  = exp_neg ? sig_tiny : s1_sig_q;
    exp_eff  = exp_neg ? 4'h0 : s1_exp_q[3:0];

    // tininess uses the unshifted significand
    tiny = tbr_q || (s1_exp_q < fp8rp_pkg::EXP_TINY_LIMIT) || !sum_orig[7];
    ovf  = !exp_neg && ((s1_exp_q > fp8rp_pkg::EXP_MAX_FINITE) ||
                        ((s1_exp_q == fp8rp_pkg::EXP_MAX_FINITE) && sum_orig[7]));

    rbits   = sig_eff[2:0];
    rnd_any = |rbits;
    sum_eff = {1'b0, sig_eff} + {5'b0, inc};
    rsig    = sum_eff[7:3];
    exp_pack = exp_eff;

    if (rnd_any && (mode_q == fp8rp_pkg::RM_ODD)) begin
      rsig[0] = 1'b1;
    end else begin
      // exact tie goes to even
      if ((mode_q == fp8rp_pkg::RM_NEAR_EVEN) && (rbits == fp8rp_pkg::RBITS_TIE)) begin
        rsig[0] = 1'b0;
      end
      if (rsig == 5'h0) begin
        exp_pack = 4'h0;
      end
    end

    // hidden bit carries into the exponent field by addition
    packed_sum = {1'b0, s1_sign_q, 7'b0} + {2'b0, exp_pack, 3'b0} + {4'b0, rsig};

    if (ovf) begin
      packed_d    = {s1_sign_q, (inc == 3'h0) ? fp8rp_pkg::ENC_MAX_FIN : fp8rp_pkg::ENC_INF};
      inexact_d   = 1'b1;
      underflow_d = 1'b0;
    end else begin
      packed_d    = packed_sum[7:0];
      inexact_d   = rnd_any;
      underflow_d = exp_neg && tiny && rnd_any;
    end
  end

  // result register
  logic [7:0] res_packed_q;
  logic       res_inexact_q, res_underflow_q, res_overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      res_packed_q    <= packed_d;
      res_inexact_q   <= inexact_d;
      res_underflow_q <= underflow_d;
      res_overflow_q  <= ovf;
    end
  end

  assign res_o.valid          = s2_v_q;
  assign res_o.packed_result  = res_packed_q;
  assign res_o.inexact_flag   = res_inexact_q;
  assign res_o.underflow_flag = res_underflow_q;
  assign res_o.overflow_flag  = res_overflow_q;

  // overflow and underflow always come with inexact
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && (res_overflow_q || res_underflow_q) |-> res_inexact_q)
    else $error("overflow or underflow without inexact");

  // overflow never sets underflow and packs infinity or the largest finite value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && res_overflow_q |-> !res_underflow_q &&
      ((res_packed_q[6:0] == fp8rp_pkg::ENC_INF) ||
       (res_packed_q[6:0] == fp8rp_pkg::ENC_MAX_FIN)))
    else $error("bad overflow encoding");

  // an underflowing result is subnormal or rounded up to the smallest normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && res_underflow_q |-> (res_packed_q[6:4] == 3'b000))
    else $error("underflow with large exponent");

  // a request in the input stage reaches the result register when it advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_en |=> s2_v_q)
    else $error("request lost between stages");

  // a result that waits keeps the input side from overwriting a held request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_v_q && !res_o.ready |-> !req_i.ready)
    else $error("ready high while both stages stalled");

endmodule
